// ===== hdl/dbps_pkg.sv =====
// Shared types, constants and tables for the drag ballistic pitch solver.
// No dependencies; used by dbps_cordic, the solver top level and the testbench files.
`default_nettype none

package dbps_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MUZZLE_SPEED = 3'd0;
    localparam logic [2:0] CFG_GRAVITY      = 3'd1;
    localparam logic [2:0] CFG_DRAG         = 3'd2;
    localparam logic [2:0] CFG_TIME_STEP    = 3'd3;
    localparam logic [2:0] CFG_STOP_ERROR   = 3'd4;
    localparam logic [2:0] CFG_MAX_ITER     = 3'd5;

    // register values after reset
    localparam logic [22:0] RST_MUZZLE_SPEED = 23'd1559757;
    localparam logic [20:0] RST_GRAVITY      = 21'd642908;
    localparam logic [23:0] RST_DRAG         = 24'd16777;
    localparam logic [20:0] RST_TIME_STEP    = 21'd83886;
    localparam logic [15:0] RST_STOP_ERROR   = 16'd66;
    localparam logic [3:0]  RST_MAX_ITER     = 4'd5;

    // CORDIC gain inverse, Q30
    localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
    localparam logic [4:0]  CORDIC_LAST  = 5'd29;
    // flight limits: step cap, 2 s in 2^-24 s units, +-1024 m/s in Q16
    localparam logic [12:0] STEP_CAP     = 13'd4096;
    localparam logic [33:0] TIME_LIMIT   = 34'd33554432;
    localparam logic signed [39:0] VEL_LIM = 40'sd67108864;

    // request to the CORDIC unit
    typedef struct packed {
        logic start;
        logic vectoring;   // 1: vectoring (atan2), 0: rotation
    } cordic_cmd_t;

    // arctangent of 2^-i, Q30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dbps_mul.sv =====
// Shared unsigned multiplier, 40 x 32 bits, built from one 20 x 32 array
// used in two passes. Depends on nothing; used by the solver top level.
`default_nettype none

module dbps_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [39:0] a_in,
    input  wire logic [31:0] b_in,
    output logic             done,
    output logic [71:0]      prod
);

    logic [39:0] a_reg;
    logic [31:0] b_reg;
    logic        ph1_reg, ph2_reg, done_reg;
    logic [51:0] lo_reg;
    logic [71:0] prod_reg;
    logic [19:0] part;
    logic [51:0] pp;

    // low half first, high half second
    assign part = ph2_reg ? a_reg[39:20] : a_reg[19:0];
    assign pp   = part * b_reg;

    // pass control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph1_reg  <= 1'b0;
            ph2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            ph1_reg  <= start;
            ph2_reg  <= ph1_reg;
            done_reg <= ph2_reg;
        end
    end

    // operands and partial products
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a_in;
            b_reg <= b_in;
        end
        if (ph1_reg) begin
            lo_reg <= pp;
        end
        if (ph2_reg) begin
            prod_reg <= {20'd0, lo_reg} + {pp, 20'd0};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hdl/dbps_sqrt.sv =====
// Bit-serial floor square root of a 64-bit value, one result bit a cycle.
// Depends on nothing; used by the solver top level.
`default_nettype none

module dbps_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] rad_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [34:0] rem_sh, trial;
    logic        fits;

    assign rem_sh = {rem_reg[32:0], rad_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring root step
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= 35'd0;
            root_reg <= 32'd0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (fits) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hdl/dbps_cordic.sv =====
// CORDIC unit, 30 micro-rotations one per cycle, vectoring or rotation mode.
// Depends on dbps_pkg (arctangent table, request struct).
`default_nettype none

module dbps_cordic (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dbps_pkg::cordic_cmd_t cmd,
    input  wire logic signed [35:0]    x0,
    input  wire logic signed [35:0]    y0,
    input  wire logic signed [32:0]    z0,
    output logic                       done,
    output logic signed [35:0]         x_out,
    output logic signed [35:0]         y_out,
    output logic signed [32:0]         z_out
);

    logic signed [35:0] x_reg, y_reg, xs, ys;
    logic signed [32:0] z_reg, ang;
    logic [4:0]         i_reg;
    logic               busy_reg, done_reg, vec_reg;

    assign xs  = x_reg >>> i_reg;
    assign ys  = y_reg >>> i_reg;
    assign ang = $signed({3'b000, dbps_pkg::atan_q30(i_reg)});

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                i_reg    <= 5'd0;
            end else if (busy_reg) begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == dbps_pkg::CORDIC_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // micro-rotation
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
            vec_reg <= cmd.vectoring;
        end else if (busy_reg) begin
            if (vec_reg) begin
                // drive y toward zero; no move when y is already zero
                if (y_reg > 36'sd0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end else if (y_reg < 36'sd0) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end
            end else begin
                // drive z toward zero
                if (z_reg >= 33'sd0) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - ang;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + ang;
                end
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

// ===== hdl/drag_ballistic_pitch_solver_core.sv =====
// Drag ballistic pitch solver: sequencer, configuration registers, handshakes.
// Depends on dbps_pkg, dbps_mul, dbps_sqrt and dbps_cordic.
//
// Use: one request on the s_ stream carries target distance and height; one
// result on the m_ stream returns launch pitch and flight time. s_tready is
// high only while the solver is idle, so one request is solved at a time.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once
// and belong to idle periods between requests.
// Datapath: all work runs through one two-pass multiplier, a bit-serial
// square root and a one-step-a-cycle CORDIC. Each shooting round flies one
// Euler trajectory; steps per flight are at most 4096 and end early at the
// target distance or at 2 s of flight.
// The result sits in an output register; a stalled receiver holds the solver
// in its finish state until the previous result is taken.
// Reset (aresetn low, synchronous) returns the registers to their default
// values, drops any solve in progress and clears m_tvalid.
`default_nettype none

module drag_ballistic_pitch_solver_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // horizontal_distance[23:0], height_difference[47:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // launch_pitch[17:0], flight_time[35:18], zero pad
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata
);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b000000000001,
        ST_MUL_GO    = 12'b000000000010,
        ST_MUL_WAIT  = 12'b000000000100,
        ST_SQ_GO     = 12'b000000001000,
        ST_SQ_WAIT   = 12'b000000010000,
        ST_ANG_NORM  = 12'b000000100000,
        ST_CD_GO     = 12'b000001000000,
        ST_CD_WAIT   = 12'b000010000000,
        ST_RND_CHECK = 12'b000100000000,
        ST_FLY_CHECK = 12'b001000000000,
        ST_RND_END   = 12'b010000000000,
        ST_DONE      = 12'b100000000000
    } state_t;

    typedef enum logic [3:0] {
        OP_V2, OP_GD, OP_V2SQ, OP_GDSQ, OP_HV, OP_HVG, OP_CX0, OP_VXSQ,
        OP_VYSQ, OP_KV, OP_AX, OP_AY, OP_DVX, OP_DVY, OP_DX, OP_DY
    } mul_op_t;

    // configuration
    logic [22:0] ms_reg;
    logic [20:0] g_reg;
    logic [23:0] k_reg;
    logic [20:0] dt_reg;
    logic [15:0] stop_reg;
    logic [3:0]  maxit_reg;

    // sequencer state
    state_t  state_reg, state_next;
    mul_op_t mop_reg, mop_next;
    logic [3:0] it_reg, it_next;
    logic sq_fly_reg, sq_fly_next;
    logic vec_reg, vec_next;

    // solve data
    logic [23:0]        dist_reg, dist_next;
    logic signed [23:0] h_reg, h_next;
    logic [29:0]        v2_reg, v2_next;
    logic [28:0]        gd_reg, gd_next;
    logic signed [63:0] disc_reg, disc_next;
    logic [37:0]        hvm_reg, hvm_next;
    logic               hvn_reg, hvn_next;
    logic signed [17:0] pitch_reg, pitch_next;
    logic signed [47:0] yaim_reg, yaim_next;
    logic [17:0]        tfly_reg, tfly_next;
    logic [47:0]        ux_reg, ux_next, uy_reg, uy_next;
    logic               yneg_reg, yneg_next;
    logic [31:0]        cx0_reg, cx0_next;

    // flight data
    logic signed [27:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [39:0] x_reg, x_next;
    logic signed [47:0] y_reg, y_next;
    logic [33:0]        t_reg, t_next;
    logic [12:0]        n_reg, n_next;
    logic [53:0]        sq_reg, sq_next;
    logic [26:0]        vm_reg, vm_next;
    logic [26:0]        kv_reg, kv_next;
    logic signed [39:0] ax_reg, ax_next, ay_reg, ay_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [17:0] m_pitch_reg, m_pitch_next, m_time_reg, m_time_next;

    // shared units
    logic        mul_start, mul_done;
    logic [39:0] mul_a;
    logic [31:0] mul_b;
    logic [71:0] p;
    logic        sq_start, sq_done;
    logic [63:0] sq_in;
    logic [31:0] sq_root;
    dbps_pkg::cordic_cmd_t cd_cmd;
    logic signed [35:0] cd_x0, cd_y0, cd_x, cd_y;
    logic signed [32:0] cd_z0, cd_z;
    logic        cd_done;

    // helper values
    logic [23:0]        h_abs;
    logic [27:0]        vx_abs, vy_abs;
    logic [39:0]        ax_abs, ay_abs;
    logic signed [47:0] h_ext, err, yaim_sum;
    logic [47:0]        err_abs, yaim_abs;
    logic signed [63:0] hvg2, disc_hvg;
    logic signed [31:0] yv;
    logic [31:0]        yv_abs;
    logic signed [32:0] z_rnd;
    logic signed [17:0] r18;
    logic signed [39:0] m40, ax_val, ay_val;
    logic signed [39:0] dv40, dvx_s, dvy_s, vx_sum, vy_sum;
    logic signed [39:0] d40, dx_s;
    logic signed [47:0] dy_s;
    logic [33:0]        t_sum;
    logic [47:0]        norm_or;

    function automatic logic signed [27:0] clamp_vel(input logic signed [39:0] v);
        logic signed [27:0] r;
        if (v > dbps_pkg::VEL_LIM) begin
            r = dbps_pkg::VEL_LIM[27:0];
        end else if (v < -dbps_pkg::VEL_LIM) begin
            r = 28'(-dbps_pkg::VEL_LIM);
        end else begin
            r = v[27:0];
        end
        return r;
    endfunction

    // magnitudes and sums
    assign h_abs    = h_reg[23] ? (24'd0 - h_reg) : h_reg;
    assign vx_abs   = vx_reg[27] ? (28'd0 - vx_reg) : vx_reg;
    assign vy_abs   = vy_reg[27] ? (28'd0 - vy_reg) : vy_reg;
    assign ax_abs   = ax_reg[39] ? (40'd0 - ax_reg) : ax_reg;
    assign ay_abs   = ay_reg[39] ? (40'd0 - ay_reg) : ay_reg;
    assign h_ext    = {{24{h_reg[23]}}, h_reg};
    assign err      = h_ext - y_reg;
    assign err_abs  = err[47] ? (48'd0 - err) : err;
    assign yaim_sum = yaim_reg + err;
    assign yaim_abs = yaim_sum[47] ? (48'd0 - yaim_sum) : yaim_sum;
    assign hvg2     = $signed({5'd0, p[57:0], 1'b0});
    assign disc_hvg = hvn_reg ? (disc_reg + hvg2) : (disc_reg - hvg2);
    assign yv       = $signed({2'b00, v2_reg}) - $signed({1'b0, sq_root[30:0]});
    assign yv_abs   = yv[31] ? (32'd0 - yv) : yv;
    assign z_rnd    = (cd_z + 33'sd8192) >>> 14;
    assign r18      = z_rnd[17:0];
    assign norm_or  = ux_reg | uy_reg;

    // drag and Euler terms from the multiplier result
    assign m40    = $signed({2'b00, p[53:16]});
    assign ax_val = vx_reg[27] ? m40 : -m40;
    assign ay_val = (vy_reg[27] ? m40 : -m40) - $signed({19'd0, g_reg});
    assign dv40   = $signed({4'd0, p[59:24]});
    assign dvx_s  = ax_reg[39] ? -dv40 : dv40;
    assign dvy_s  = ay_reg[39] ? -dv40 : dv40;
    assign vx_sum = 40'(vx_reg) + dvx_s;
    assign vy_sum = 40'(vy_reg) + dvy_s;
    assign d40    = $signed({17'd0, p[46:24]});
    assign dx_s   = vx_reg[27] ? -d40 : d40;
    assign dy_s   = vy_reg[27] ? -48'(d40) : 48'(d40);
    assign t_sum  = t_reg + {13'd0, dt_reg};

    // multiplier operand select
    always_comb begin
        unique case (mop_reg)
            OP_V2:   begin mul_a = 40'(ms_reg);              mul_b = 32'(ms_reg);  end
            OP_GD:   begin mul_a = 40'(dist_reg);            mul_b = 32'(g_reg);   end
            OP_V2SQ: begin mul_a = 40'(v2_reg);              mul_b = 32'(v2_reg);  end
            OP_GDSQ: begin mul_a = 40'(gd_reg);              mul_b = 32'(gd_reg);  end
            OP_HV:   begin mul_a = 40'(h_abs);               mul_b = 32'(v2_reg);  end
            OP_HVG:  begin mul_a = 40'(hvm_reg);             mul_b = 32'(g_reg);   end
            OP_CX0:  begin mul_a = 40'({ms_reg, 8'd0});      mul_b = dbps_pkg::INV_GAIN_Q30; end
            OP_VXSQ: begin mul_a = 40'(vx_abs);              mul_b = 32'(vx_abs);  end
            OP_VYSQ: begin mul_a = 40'(vy_abs);              mul_b = 32'(vy_abs);  end
            OP_KV:   begin mul_a = 40'(vm_reg);              mul_b = 32'(k_reg);   end
            OP_AX:   begin mul_a = 40'(kv_reg);              mul_b = 32'(vx_abs);  end
            OP_AY:   begin mul_a = 40'(kv_reg);              mul_b = 32'(vy_abs);  end
            OP_DVX:  begin mul_a = ax_abs;                   mul_b = 32'(dt_reg);  end
            OP_DVY:  begin mul_a = ay_abs;                   mul_b = 32'(dt_reg);  end
            OP_DX:   begin mul_a = 40'(vx_abs);              mul_b = 32'(dt_reg);  end
            OP_DY:   begin mul_a = 40'(vy_abs);              mul_b = 32'(dt_reg);  end
        endcase
    end

    assign mul_start = (state_reg == ST_MUL_GO);
    assign sq_start  = (state_reg == ST_SQ_GO);
    assign sq_in     = sq_fly_reg ? {10'd0, sq_reg} : disc_reg;
    assign cd_cmd    = '{start: (state_reg == ST_CD_GO), vectoring: vec_reg};
    assign cd_x0 = vec_reg ? $signed({6'd0, ux_reg[29:0]}) : $signed({4'd0, cx0_reg});
    assign cd_y0 = vec_reg ? $signed({6'd0, uy_reg[29:0]}) : 36'sd0;
    assign cd_z0 = vec_reg ? 33'sd0 : 33'($signed({pitch_reg, 14'd0}));

    dbps_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .prod    (p)
    );

    dbps_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    dbps_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cd_cmd),
        .x0      (cd_x0),
        .y0      (cd_y0),
        .z0      (cd_z0),
        .done    (cd_done),
        .x_out   (cd_x),
        .y_out   (cd_y),
        .z_out   (cd_z)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        mop_next     = mop_reg;
        it_next      = it_reg;
        sq_fly_next  = sq_fly_reg;
        vec_next     = vec_reg;
        dist_next    = dist_reg;
        h_next       = h_reg;
        v2_next      = v2_reg;
        gd_next      = gd_reg;
        disc_next    = disc_reg;
        hvm_next     = hvm_reg;
        hvn_next     = hvn_reg;
        pitch_next   = pitch_reg;
        yaim_next    = yaim_reg;
        tfly_next    = tfly_reg;
        ux_next      = ux_reg;
        uy_next      = uy_reg;
        yneg_next    = yneg_reg;
        cx0_next     = cx0_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        t_next       = t_reg;
        n_next       = n_reg;
        sq_next      = sq_reg;
        vm_next      = vm_reg;
        kv_next      = kv_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        m_pitch_next = m_pitch_reg;
        m_time_next  = m_time_reg;
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    dist_next  = s_tdata[23:0];
                    h_next     = s_tdata[47:24];
                    yaim_next  = {{24{s_tdata[47]}}, s_tdata[47:24]};
                    it_next    = 4'd0;
                    tfly_next  = 18'd0;
                    mop_next   = OP_V2;
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO: begin
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    state_next = ST_MUL_GO;
                    unique case (mop_reg)
                        OP_V2: begin
                            v2_next  = p[45:16];
                            mop_next = OP_GD;
                        end
                        OP_GD: begin
                            gd_next  = p[44:16];
                            mop_next = OP_V2SQ;
                        end
                        OP_V2SQ: begin
                            disc_next = $signed({4'd0, p[59:0]});
                            mop_next  = OP_GDSQ;
                        end
                        OP_GDSQ: begin
                            disc_next = disc_reg - $signed({6'd0, p[57:0]});
                            mop_next  = OP_HV;
                        end
                        OP_HV: begin
                            hvm_next = p[53:16];
                            hvn_next = h_reg[23];
                            mop_next = OP_HVG;
                        end
                        OP_HVG: begin
                            disc_next = disc_hvg;
                            if (disc_hvg[63]) begin
                                // no real parabola: aim along the line of sight
                                ux_next    = 48'(dist_reg);
                                uy_next    = 48'(h_abs);
                                yneg_next  = h_reg[23];
                                state_next = ST_ANG_NORM;
                            end else begin
                                sq_fly_next = 1'b0;
                                state_next  = ST_SQ_GO;
                            end
                        end
                        OP_CX0: begin
                            cx0_next   = p[61:30];
                            vec_next   = 1'b0;
                            state_next = ST_CD_GO;
                        end
                        OP_VXSQ: begin
                            sq_next  = p[53:0];
                            mop_next = OP_VYSQ;
                        end
                        OP_VYSQ: begin
                            sq_next     = sq_reg + p[53:0];
                            sq_fly_next = 1'b1;
                            state_next  = ST_SQ_GO;
                        end
                        OP_KV: begin
                            kv_next  = p[50:24];
                            mop_next = OP_AX;
                        end
                        OP_AX: begin
                            ax_next  = ax_val;
                            mop_next = OP_AY;
                        end
                        OP_AY: begin
                            ay_next  = ay_val;
                            mop_next = OP_DVX;
                        end
                        OP_DVX: begin
                            vx_next  = clamp_vel(vx_sum);
                            mop_next = OP_DVY;
                        end
                        OP_DVY: begin
                            vy_next  = clamp_vel(vy_sum);
                            mop_next = OP_DX;
                        end
                        OP_DX: begin
                            x_next   = x_reg + dx_s;
                            mop_next = OP_DY;
                        end
                        OP_DY: begin
                            y_next = y_reg + dy_s;
                            t_next = t_sum;
                            n_next = n_reg + 13'd1;
                            if (t_sum > dbps_pkg::TIME_LIMIT) begin
                                state_next = ST_RND_END;
                            end else begin
                                state_next = ST_FLY_CHECK;
                            end
                        end
                    endcase
                end
            end
            ST_SQ_GO: begin
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (sq_done) begin
                    if (sq_fly_reg) begin
                        vm_next    = sq_root[26:0];
                        mop_next   = OP_KV;
                        state_next = ST_MUL_GO;
                    end else begin
                        // low-angle parabola solution
                        ux_next    = 48'(gd_reg);
                        uy_next    = 48'(yv_abs);
                        yneg_next  = yv[31];
                        state_next = ST_ANG_NORM;
                    end
                end
            end
            ST_ANG_NORM: begin
                // bring operands into [2^29, 2^30) one shift a cycle
                if (norm_or == 48'd0) begin
                    pitch_next = 18'sd0;
                    state_next = ST_RND_CHECK;
                end else if (norm_or[47:30] != 18'd0) begin
                    ux_next = ux_reg >> 1;
                    uy_next = uy_reg >> 1;
                end else if (!norm_or[29]) begin
                    ux_next = ux_reg << 1;
                    uy_next = uy_reg << 1;
                end else begin
                    vec_next   = 1'b1;
                    state_next = ST_CD_GO;
                end
            end
            ST_CD_GO: begin
                state_next = ST_CD_WAIT;
            end
            ST_CD_WAIT: begin
                if (cd_done) begin
                    if (vec_reg) begin
                        pitch_next = yneg_reg ? -r18 : r18;
                        state_next = ST_RND_CHECK;
                    end else begin
                        // launch velocity from rotated muzzle speed
                        vx_next    = 28'(cd_x >>> 8);
                        vy_next    = 28'(cd_y >>> 8);
                        x_next     = 40'sd0;
                        y_next     = 48'sd0;
                        t_next     = 34'd0;
                        n_next     = 13'd0;
                        state_next = ST_FLY_CHECK;
                    end
                end
            end
            ST_RND_CHECK: begin
                if (it_reg < maxit_reg) begin
                    mop_next   = OP_CX0;
                    state_next = ST_MUL_GO;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FLY_CHECK: begin
                if ((x_reg < $signed({16'd0, dist_reg})) && (n_reg < dbps_pkg::STEP_CAP)) begin
                    mop_next   = OP_VXSQ;
                    state_next = ST_MUL_GO;
                end else begin
                    state_next = ST_RND_END;
                end
            end
            ST_RND_END: begin
                tfly_next = t_reg[25:8];
                if (err_abs < 48'(stop_reg)) begin
                    state_next = ST_DONE;
                end else begin
                    // shift aim by the miss and re-aim
                    yaim_next  = yaim_sum;
                    ux_next    = 48'(dist_reg);
                    uy_next    = yaim_abs;
                    yneg_next  = yaim_sum[47];
                    it_next    = it_reg + 4'd1;
                    state_next = ST_ANG_NORM;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_pitch_next = pitch_reg;
                    m_time_next  = tfly_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ms_reg      <= dbps_pkg::RST_MUZZLE_SPEED;
            g_reg       <= dbps_pkg::RST_GRAVITY;
            k_reg       <= dbps_pkg::RST_DRAG;
            dt_reg      <= dbps_pkg::RST_TIME_STEP;
            stop_reg    <= dbps_pkg::RST_STOP_ERROR;
            maxit_reg   <= dbps_pkg::RST_MAX_ITER;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    dbps_pkg::CFG_MUZZLE_SPEED: ms_reg    <= cfg_wdata[22:0];
                    dbps_pkg::CFG_GRAVITY:      g_reg     <= cfg_wdata[20:0];
                    dbps_pkg::CFG_DRAG:         k_reg     <= cfg_wdata;
                    dbps_pkg::CFG_TIME_STEP:    dt_reg    <= cfg_wdata[20:0];
                    dbps_pkg::CFG_STOP_ERROR:   stop_reg  <= cfg_wdata[15:0];
                    dbps_pkg::CFG_MAX_ITER:     maxit_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    // data registers
    always_ff @(posedge aclk) begin
        mop_reg     <= mop_next;
        it_reg      <= it_next;
        sq_fly_reg  <= sq_fly_next;
        vec_reg     <= vec_next;
        dist_reg    <= dist_next;
        h_reg       <= h_next;
        v2_reg      <= v2_next;
        gd_reg      <= gd_next;
        disc_reg    <= disc_next;
        hvm_reg     <= hvm_next;
        hvn_reg     <= hvn_next;
        pitch_reg   <= pitch_next;
        yaim_reg    <= yaim_next;
        tfly_reg    <= tfly_next;
        ux_reg      <= ux_next;
        uy_reg      <= uy_next;
        yneg_reg    <= yneg_next;
        cx0_reg     <= cx0_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        t_reg       <= t_next;
        n_reg       <= n_next;
        sq_reg      <= sq_next;
        vm_reg      <= vm_next;
        kv_reg      <= kv_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        m_pitch_reg <= m_pitch_next;
        m_time_reg  <= m_time_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_time_reg, m_pitch_reg};

endmodule

`default_nettype wire

// ===== tb/dbps_checker.sv =====
// Checker for the drag ballistic pitch solver: mirrors config writes, predicts each
// solve bit-exactly, and compares every result field. Depends on dbps_pkg.
`timescale 1ns / 1ps

module dbps_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // horizontal_distance[23:0], height_difference[47:24]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // launch_pitch[17:0], flight_time[35:18], zero pad
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [17:0] flight_time;
        logic [17:0] launch_pitch;
    } solution_t;

    // arctangent of 2^-i, Q30
    localparam longint ARCTAN [0:29] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2};
    localparam longint GAIN_INV   = 652032874;
    localparam longint SPEED_CAP  = 64'sd67108864;
    localparam longint unsigned FLIGHT_LIMIT = 64'd33554432;

    // mirrored configuration
    longint unsigned speed_q16, grav_q16, drag_k, dt_step, miss_tol, round_limit;

    solution_t solutions_q[$];

    function automatic longint unsigned magnitude(longint a);
        return longint'(a < 0 ? -a : a);
    endfunction

    // (a*b)>>s truncated toward zero
    function automatic longint mul_shift(longint a, longint b, int s);
        longint unsigned p;
        p = (magnitude(a) * magnitude(b)) >> s;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring CORDIC, x >= 0, result Q16 radians
    function automatic longint aim_angle(longint y, longint unsigned x);
        longint unsigned ux, uy;
        longint cx, cy, z, nx, r;
        ux = x;
        uy = magnitude(y);
        z = 0;
        if (ux == 0 && uy == 0) return 0;
        while ((ux | uy) >= (64'd1 << 30)) begin
            ux = ux >> 1;
            uy = uy >> 1;
        end
        while ((ux | uy) < (64'd1 << 29)) begin
            ux = ux << 1;
            uy = uy << 1;
        end
        cx = longint'(ux);
        cy = longint'(uy);
        for (int i = 0; i < 30; i++) begin
            if (cy > 0) begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cx = nx;
                z = z + ARCTAN[i];
            end else if (cy < 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cx = nx;
                z = z - ARCTAN[i];
            end
        end
        r = (z + 8192) >>> 14;
        return y < 0 ? -r : r;
    endfunction

    function automatic longint limit_speed(longint v);
        if (v > SPEED_CAP) return SPEED_CAP;
        if (v < -SPEED_CAP) return -SPEED_CAP;
        return v;
    endfunction

    // one Euler flight with drag; returns final height, flight time via t_out
    function automatic longint fly_height(longint pitch, longint unsigned range_x,
                                          output longint unsigned t_out);
        longint cx, cy, z, nx, vx, vy, px, py, kv, ax, ay, dt, g;
        longint unsigned t, vm;
        int n;
        cx = mul_shift(longint'(speed_q16 << 8), GAIN_INV, 30);
        cy = 0;
        z = pitch * 16384;
        dt = longint'(dt_step);
        g = longint'(grav_q16);
        px = 0;
        py = 0;
        t = 0;
        n = 0;
        // rotate launch speed onto the pitch
        for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z = z - ARCTAN[i];
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z = z + ARCTAN[i];
            end
            cx = nx;
        end
        vx = cx >>> 8;
        vy = cy >>> 8;
        while (px < longint'(range_x) && n < 4096) begin
            vm = floor_sqrt(magnitude(vx) * magnitude(vx) + magnitude(vy) * magnitude(vy));
            kv = longint'((drag_k * vm) >> 24);
            ax = -mul_shift(kv, vx, 16);
            ay = -g - mul_shift(kv, vy, 16);
            vx = limit_speed(vx + mul_shift(ax, dt, 24));
            vy = limit_speed(vy + mul_shift(ay, dt, 24));
            px = px + mul_shift(vx, dt, 24);
            py = py + mul_shift(vy, dt, 24);
            t = t + dt_step;
            n++;
            if (t > FLIGHT_LIMIT) break;
        end
        t_out = t;
        return py;
    endfunction

    function automatic solution_t solve_pitch(logic [23:0] dist_in, logic [23:0] hgt_in);
        longint unsigned range_x, v2, gd, t, tfly;
        longint h, disc, pitch, yaim, miss;
        solution_t res;
        range_x = longint'(dist_in);
        h = longint'($signed(hgt_in));
        t = 0;
        tfly = 0;
        v2 = (speed_q16 * speed_q16) >> 16;
        gd = (grav_q16 * range_x) >> 16;
        disc = longint'(v2 * v2) - longint'(gd * gd)
             - 2 * mul_shift(mul_shift(h, longint'(v2), 16), longint'(grav_q16), 0);
        // no drag-free solution: aim along the line of sight
        if (disc < 0)
            pitch = aim_angle(h, range_x);
        else
            pitch = aim_angle(longint'(v2) - longint'(floor_sqrt(longint'(disc))), gd);
        yaim = h;
        for (longint unsigned it = 0; it < round_limit; it++) begin
            miss = h - fly_height(pitch, range_x, t);
            tfly = t;
            if (magnitude(miss) < miss_tol) break;
            yaim = yaim + miss;
            pitch = aim_angle(yaim, range_x);
        end
        res.launch_pitch = pitch[17:0];
        res.flight_time = tfly[25:8];
        return res;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        solution_t want, got;
        if (!aresetn) begin
            speed_q16   = dbps_pkg::RST_MUZZLE_SPEED;
            grav_q16    = dbps_pkg::RST_GRAVITY;
            drag_k      = dbps_pkg::RST_DRAG;
            dt_step     = dbps_pkg::RST_TIME_STEP;
            miss_tol    = dbps_pkg::RST_STOP_ERROR;
            round_limit = dbps_pkg::RST_MAX_ITER;
            solutions_q.delete();
        end else begin
            // config mirror
            if (cfg_wr_en) begin
                case (cfg_index)
                    dbps_pkg::CFG_MUZZLE_SPEED: speed_q16   = cfg_wdata[22:0];
                    dbps_pkg::CFG_GRAVITY:      grav_q16    = cfg_wdata[20:0];
                    dbps_pkg::CFG_DRAG:         drag_k      = cfg_wdata[23:0];
                    dbps_pkg::CFG_TIME_STEP:    dt_step     = cfg_wdata[20:0];
                    dbps_pkg::CFG_STOP_ERROR:   miss_tol    = cfg_wdata[15:0];
                    dbps_pkg::CFG_MAX_ITER:     round_limit = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                solutions_q.push_back(solve_pitch(s_tdata[23:0], s_tdata[47:24]));
            // compare result against oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata[35:0];
                if (solutions_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = solutions_q.pop_front();
                    if (want.launch_pitch !== got.launch_pitch ||
                        want.flight_time !== got.flight_time) begin
                        $display("%0t: pitch exp %h got %h, time exp %h got %h", $time,
                                 want.launch_pitch, got.launch_pitch,
                                 want.flight_time, got.flight_time);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= solutions_q.size();
    end

endmodule

// ===== tb/drag_ballistic_pitch_solver_core_tb.sv =====
// Testbench top for drag_ballistic_pitch_solver_core: drives requests, config and
// receiver stalls; checking is done by dbps_checker. Depends on dbps_pkg.
`timescale 1ns / 1ps

module drag_ballistic_pitch_solver_core_tb;

    // the step-cap case is the longest single solve here
    localparam int IDLE_LIMIT = 2000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = dbps_pkg::CFG_MUZZLE_SPEED;
    logic [23:0] cfg_wdata = '0;

    int fail_count, pending;
    int burst_left = 4;
    int requests_sent = 0;
    int settings_used = 1;
    int idle_cycles = 0;
    bit hold_req = 0;

    always #10 aclk = ~aclk;

    drag_ballistic_pitch_solver_core uut (.*);

    dbps_checker checker_i (.*);

    // receiver: random stall patterns plus one long hold-off on request
    always @(posedge aclk) begin
        static int hold_cnt = 0, mode = 0, mode_cnt = 0;
        static bit hold_done = 0;
        if (hold_req && !hold_done) begin
            hold_done = 1;
            // longer than two solves, so a result waits and the input stalls
            hold_cnt = 40000;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            if (mode_cnt == 0) begin
                mode = $urandom_range(0, 2);
                mode_cnt = $urandom_range(50, 400);
            end
            mode_cnt--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("drag_ballistic_pitch_solver_core_tb: errors");
            $finish;
        end
    end

    // offer one request, hold until taken, then maybe idle a while
    task automatic send_request(input logic [23:0] range_in, input logic [23:0] hgt);
        s_tdata <= {hgt, range_in};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // drain all expected results, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_config(input logic [23:0] speed, input logic [23:0] grav,
                                input logic [23:0] drag, input logic [23:0] dt,
                                input logic [23:0] tol, input logic [23:0] rounds);
        logic [23:0] vals [6];
        logic [2:0]  idxs [6];
        vals = '{speed, grav, drag, dt, tol, rounds};
        idxs = '{dbps_pkg::CFG_MUZZLE_SPEED, dbps_pkg::CFG_GRAVITY, dbps_pkg::CFG_DRAG,
                 dbps_pkg::CFG_TIME_STEP, dbps_pkg::CFG_STOP_ERROR, dbps_pkg::CFG_MAX_ITER};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idxs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // reset settings: short shots, zero distance, no drag-free solution
        send_request(24'd0, 24'd0);
        send_request(24'd0, 24'h7FFFFF);
        send_request(24'd0, 24'h800000);
        send_request(24'd1, 24'd1);
        send_request(24'd65536, 24'd0);
        send_request(24'd131072, 24'd65536);
        send_request(24'd196608, -24'sd131072);
        send_request(24'd327680, 24'h7FFFFF);
        send_request(24'd3932160, 24'd0);
        wait_idle();

        // top extremes: fast, heavy gravity, no drag, coarse step, never converges
        write_config(24'h7FFFFF, 24'h1FFFFF, 24'd0, 24'd1048576, 24'd0, 24'd15);
        send_request(24'hFFFFFF, 24'h7FFFFF);
        send_request(24'hFFFFFF, 24'h800000);
        send_request(24'hFFFFFF, 24'd0);
        send_request(24'h800000, 24'h400000);
        wait_idle();

        // slowest speed, no gravity, full drag, zero rounds
        write_config(24'd65536, 24'd0, 24'hFFFFFF, 24'd524288, 24'hFFFF, 24'd0);
        send_request(24'hFFFFFF, 24'h7FFFFF);
        send_request(24'd0, 24'h800000);
        send_request(24'd1234567, 24'd0);
        wait_idle();

        // smallest time step: flight ends on the step cap
        write_config(24'd65536, 24'd642908, 24'd16777, 24'd1, 24'd66, 24'd1);
        send_request(24'd65536, 24'd0);
        wait_idle();

        // random settings, random targets
        for (int p = 0; p < 4; p++) begin
            write_config($urandom_range(65536, 8388607), $urandom_range(0, 2097151),
                         ($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 16777215)),
                         $urandom_range(524288, 1048576),
                         ($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 65535)),
                         $urandom_range(0, 3));
            if (p == 1) hold_req = 1;
            for (int k = 0; k < 25; k++)
                send_request($urandom_range(0, 1) ? $urandom_range(0, 1310720)
                                                  : $urandom_range(0, 16777215),
                             $urandom());
            wait_idle();
        end

        $display("covered %0d solve requests over %0d register settings,", requests_sent,
                 settings_used);
        $display("including zero-round, step-cap and receiver hold-off cases");
        if (fail_count == 0 && pending == 0)
            $display("drag_ballistic_pitch_solver_core_tb: clean");
        else
            $display("drag_ballistic_pitch_solver_core_tb: errors");
        $finish;
    end

endmodule
